@@ sv/text_console_cursor_engine_unit_defines.svh @@
// Assertion macros for the text console cursor engine.
// Used by the top level only; expects signals named clock and reset in scope.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, masked while reset is high
`define TCCE_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high
`define TCCE_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/tcce_pkg.sv @@
// Shared constants for the text console cursor engine.
// No dependencies; imported by the interfaces, the top level and the testbench.
package tcce_pkg;

   // Field widths of the channels
   localparam int OPCODE_W    = 2;
   localparam int CHAR_W      = 8;
   localparam int ADDR_W      = 12;
   localparam int OUT_COL_W   = 7;
   localparam int OUT_ROW_W   = 5;
   localparam int OUT_POS_W   = 12;
   localparam int CELL_W      = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   // Default screen store dimensions
   localparam int DEF_MAX_ROWS = 32;
   localparam int DEF_MAX_COLS = 128;

   // Operation codes
   localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

   // Control characters
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_ATTRIBUTE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ROW_COUNT    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_COLUMN_COUNT = 2'd2;

   // Reset values
   localparam logic [CSR_DATA_W-1:0] ATTR_RESET = 8'd7;
   localparam int                    ROWS_RESET = 25;
   localparam int                    COLS_RESET = 80;
   localparam logic [CELL_W-1:0]     RESET_CELL = 16'h0720;

endpackage

@@ sv/tcce_if.sv @@
// Valid/ready channel interfaces of the text console cursor engine.
// Depends on tcce_pkg for the field widths.
interface tcce_req_if;
   import tcce_pkg::*;
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [CHAR_W-1:0]   char_code;
   logic [ADDR_W-1:0]   cell_address;
   modport source (output valid, opcode, char_code, cell_address, input ready);
   modport sink   (input valid, opcode, char_code, cell_address, output ready);
endinterface

interface tcce_rsp_if;
   import tcce_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [OUT_COL_W-1:0] cursor_col;
   logic [OUT_ROW_W-1:0] cursor_row;
   logic [OUT_POS_W-1:0] cursor_pos;
   logic [CELL_W-1:0]    cell_word;
   logic                 scrolled;
   modport source (output valid, cursor_col, cursor_row, cursor_pos, cell_word, scrolled,
                   input ready);
   modport sink   (input valid, cursor_col, cursor_row, cursor_pos, cell_word, scrolled,
                   output ready);
endinterface

interface tcce_csr_if;
   import tcce_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/text_console_cursor_engine_unit.sv @@
// Top level of the text console cursor engine: sequencer, registers and store.
// Depends on tcce_pkg, the channel interfaces, tcce_ram, tcce_mac and the defines header.
`include "text_console_cursor_engine_unit_defines.svh"

// Character-cell text console holding a MAX_ROWS x MAX_COLS store of 16-bit cells
// (attribute high byte, character low byte) and a cursor. After reset the block
// runs a clearing pass over all MAX_ROWS*MAX_COLS cells (4096 at the defaults)
// with req ready low; register writes are taken throughout. One transaction is worked
// at a time by a sequencer around a single shared multiply-add unit and the
// store's one write and one read port. Every transaction passes through the total,
// position, execute, final and output states, and read cell adds a read state;
// req ready rises again as the result is loaded into the output register. Clear writes
// rows*columns cells, one cell written per cycle; a put that scrolls copies the rows
// up (copy pass pipelined through the read port, then the bottom row blanked),
// or only blanks the row on a one-row screen. The result register holds a
// result until taken, and the next transaction is accepted while it waits; its
// own result then waits in the sequencer until the register is free.
module text_console_cursor_engine_unit #(
   parameter int MAX_ROWS = tcce_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = tcce_pkg::DEF_MAX_COLS
) (
   input  logic        clock,
   input  logic        reset,
   tcce_req_if.sink    req_bus,
   tcce_rsp_if.source  rsp_bus,
   tcce_csr_if.sink    csr_bus
);
   import tcce_pkg::*;

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW    = $clog2(DEPTH + 1);
   localparam int RW    = $clog2(MAX_ROWS + 1);
   localparam int CW    = $clog2(MAX_COLS + 1);
   localparam int ROWS_INIT = (ROWS_RESET > MAX_ROWS) ? MAX_ROWS : ROWS_RESET;
   localparam int COLS_INIT = (COLS_RESET > MAX_COLS) ? MAX_COLS : COLS_RESET;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_TOTAL, S_POS, S_EXEC, S_COPY, S_DRAIN,
      S_BLANK, S_CLEAR, S_READ, S_FINAL, S_OUT
   } state_type;

   state_type            state_ff;

   // configuration
   logic [CSR_DATA_W-1:0] attr_ff;
   logic [RW-1:0]         rows_ff;
   logic [CW-1:0]         cols_ff;
   logic [RW-1:0]         rows_in;
   logic [CW-1:0]         cols_in;
   logic [RW:0]           csr_rows_ext;
   logic [CW:0]           csr_cols_ext;

   // cursor and latched transaction
   logic [CW-1:0]         cur_col_ff;
   logic [RW-1:0]         cur_row_ff;
   logic [OPCODE_W-1:0]   req_op_ff;
   logic [CHAR_W-1:0]     req_char_ff;
   logic [ADDR_W-1:0]     req_addr_ff;

   // walk and copy pipeline
   logic [PW-1:0]         walk_ff;
   logic [PW-1:0]         total_ff;
   logic                  cp_valid_ff;
   logic [PW-1:0]         cp_idx_ff;
   logic                  in_range_ff;
   logic                  scrolled_ff;
   logic [CELL_W-1:0]     word_ff;

   // result register
   logic                  rsp_valid_ff;
   logic [OUT_COL_W-1:0]  rsp_col_ff;
   logic [OUT_ROW_W-1:0]  rsp_row_ff;
   logic [OUT_POS_W-1:0]  rsp_pos_ff;
   logic [CELL_W-1:0]     rsp_word_ff;
   logic                  rsp_scrolled_ff;

   // put character decision
   logic [CW-1:0]         put_col_in;
   logic [RW-1:0]         put_row_in;
   logic                  put_down;
   logic                  put_scroll;
   logic                  put_we;
   logic                  put_back;
   logic [CELL_W-1:0]     put_data;
   logic [CW:0]           col_inc;
   logic [RW:0]           row_inc;

   // shared unit and store ports
   logic                  mac_en;
   logic [RW-1:0]         mac_a;
   logic [CW-1:0]         mac_b;
   logic [CW-1:0]         mac_c;
   logic [PW-1:0]         mac_q;
   logic                  ram_we;
   logic [PW-1:0]         wr_idx;
   logic [CELL_W-1:0]     ram_wdata;
   logic [AW-1:0]         ram_raddr;
   logic [CELL_W-1:0]     ram_rdata;
   logic [CELL_W-1:0]     blank_word;
   logic                  req_fire;
   logic                  rsp_fire;

   assign blank_word = {attr_ff, CH_BLANK};
   assign req_fire   = req_bus.valid && req_bus.ready;
   assign rsp_fire   = rsp_bus.valid && rsp_bus.ready;

   // register file: counts of zero read as one, large counts saturate (row count from its low six bits)
   assign csr_bus.ready = 1'b1;
   assign csr_rows_ext  = (RW + 1)'(csr_bus.data[5:0]);
   assign csr_cols_ext  = (CW + 1)'(csr_bus.data);
   assign rows_in = (csr_rows_ext == '0)       ? RW'(1) :
                    (csr_rows_ext > MAX_ROWS)  ? RW'(MAX_ROWS) : RW'(csr_rows_ext);
   assign cols_in = (csr_cols_ext == '0)       ? CW'(1) :
                    (csr_cols_ext > MAX_COLS)  ? CW'(MAX_COLS) : CW'(csr_cols_ext);

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= ATTR_RESET;
         rows_ff <= RW'(ROWS_INIT);
         cols_ff <= CW'(COLS_INIT);
      end else if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            REG_ATTRIBUTE:    attr_ff <= csr_bus.data;
            REG_ROW_COUNT:    rows_ff <= rows_in;
            REG_COLUMN_COUNT: cols_ff <= cols_in;
            default: ;
         endcase
      end
   end

   // put character: new cursor, cell to write, row change
   assign col_inc = {1'b0, cur_col_ff} + (CW + 1)'(1);
   assign row_inc = {1'b0, cur_row_ff} + (RW + 1)'(1);

   always_comb begin
      put_col_in = cur_col_ff;
      put_row_in = cur_row_ff;
      put_down   = 1'b0;
      put_we     = 1'b0;
      put_back   = 1'b0;
      put_data   = {attr_ff, req_char_ff};
      case (req_char_ff)
         CH_NEWLINE: begin
            put_col_in = '0;
            put_down   = 1'b1;
         end
         CH_BACKSPACE: begin
            // nothing happens at the origin
            if (cur_col_ff != '0 || cur_row_ff != '0) begin
               put_we   = 1'b1;
               put_back = 1'b1;
               put_data = blank_word;
               if (cur_col_ff != '0) begin
                  put_col_in = cur_col_ff - CW'(1);
               end else begin
                  put_row_in = cur_row_ff - RW'(1);
                  put_col_in = cols_ff - CW'(1);
               end
            end
         end
         CH_RETURN: ;
         default: begin
            put_we = 1'b1;
            if (col_inc >= {1'b0, cols_ff}) begin
               put_col_in = '0;
               put_down   = 1'b1;
            end else begin
               put_col_in = col_inc[CW-1:0];
            end
         end
      endcase
      put_scroll = put_down && (row_inc >= {1'b0, rows_ff});
      if (put_down && !put_scroll) begin
         put_row_in = row_inc[RW-1:0];
      end
   end

   // shared multiply-add: screen size, then cursor position
   always_comb begin
      mac_en = 1'b0;
      mac_a  = cur_row_ff;
      mac_b  = cols_ff;
      mac_c  = cur_col_ff;
      case (state_ff)
         S_TOTAL: begin
            mac_en = 1'b1;
            mac_a  = rows_ff;
            mac_c  = '0;
         end
         S_POS, S_FINAL: mac_en = 1'b1;
         default: ;
      endcase
   end

   tcce_mac #(
      .A_W (RW),
      .B_W (CW),
      .Q_W (PW)
   ) u_mac (
      .clock (clock),
      .en    (mac_en),
      .a     (mac_a),
      .b     (mac_b),
      .c     (mac_c),
      .q     (mac_q)
   );

   // store write port selection
   always_comb begin
      ram_we    = 1'b0;
      wr_idx    = walk_ff;
      ram_wdata = blank_word;
      case (state_ff)
         S_INIT: begin
            ram_we    = 1'b1;
            ram_wdata = RESET_CELL;
         end
         S_EXEC: begin
            if (req_op_ff == OP_PUT && put_we) begin
               ram_we    = 1'b1;
               wr_idx    = put_back ? (mac_q - PW'(1)) : mac_q;
               ram_wdata = put_data;
            end
         end
         S_CLEAR, S_BLANK: ram_we = 1'b1;
         S_COPY, S_DRAIN: begin
            ram_we    = cp_valid_ff;
            wr_idx    = cp_idx_ff;
            ram_wdata = ram_rdata;
         end
         default: ;
      endcase
   end

   assign ram_raddr = (state_ff == S_EXEC) ? AW'(req_addr_ff) : walk_ff[AW-1:0];

   tcce_ram #(
      .WIDTH (CELL_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_idx[AW-1:0]),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         walk_ff      <= '0;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         cp_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a result taken while the next one is loaded stays valid
         if (rsp_fire && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_INIT: begin
               if (walk_ff == PW'(DEPTH - 1)) begin
                  walk_ff  <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  walk_ff <= walk_ff + PW'(1);
               end
            end
            S_IDLE: begin
               if (req_fire) begin
                  req_op_ff   <= req_bus.opcode;
                  req_char_ff <= req_bus.char_code;
                  req_addr_ff <= req_bus.cell_address;
                  // pull the cursor back onto a shrunken screen
                  if (cur_col_ff >= cols_ff) cur_col_ff <= cols_ff - CW'(1);
                  if (cur_row_ff >= rows_ff) cur_row_ff <= rows_ff - RW'(1);
                  scrolled_ff <= 1'b0;
                  word_ff     <= '0;
                  state_ff    <= S_TOTAL;
               end
            end
            S_TOTAL: state_ff <= S_POS;
            S_POS: begin
               total_ff <= mac_q;
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               cp_valid_ff <= 1'b0;
               case (req_op_ff)
                  OP_PUT: begin
                     cur_col_ff  <= put_col_in;
                     cur_row_ff  <= put_row_in;
                     scrolled_ff <= put_scroll;
                     if (put_scroll) begin
                        if (rows_ff == RW'(1)) begin
                           walk_ff  <= '0;
                           state_ff <= S_BLANK;
                        end else begin
                           walk_ff  <= PW'(cols_ff);
                           state_ff <= S_COPY;
                        end
                     end else begin
                        state_ff <= S_FINAL;
                     end
                  end
                  OP_CLEAR: begin
                     walk_ff  <= '0;
                     state_ff <= S_CLEAR;
                  end
                  OP_READ: begin
                     in_range_ff <= ((ADDR_W + PW)'(req_addr_ff) < (ADDR_W + PW)'(total_ff));
                     state_ff    <= S_READ;
                  end
                  default: state_ff <= S_FINAL;
               endcase
            end
            S_COPY: begin
               // read one row down, write it back in the following cycle
               cp_valid_ff <= 1'b1;
               cp_idx_ff   <= walk_ff - PW'(cols_ff);
               if (walk_ff == total_ff - PW'(1)) begin
                  state_ff <= S_DRAIN;
               end else begin
                  walk_ff <= walk_ff + PW'(1);
               end
            end
            S_DRAIN: begin
               cp_valid_ff <= 1'b0;
               walk_ff     <= total_ff - PW'(cols_ff);
               state_ff    <= S_BLANK;
            end
            S_BLANK, S_CLEAR: begin
               if (walk_ff == total_ff - PW'(1)) begin
                  state_ff <= S_FINAL;
               end else begin
                  walk_ff <= walk_ff + PW'(1);
               end
            end
            S_READ: begin
               if (in_range_ff) word_ff <= ram_rdata;
               state_ff <= S_FINAL;
            end
            S_FINAL: state_ff <= S_OUT;
            S_OUT: begin
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_col_ff      <= OUT_COL_W'(cur_col_ff);
                  rsp_row_ff      <= OUT_ROW_W'(cur_row_ff);
                  rsp_pos_ff      <= OUT_POS_W'(mac_q);
                  rsp_word_ff     <= word_ff;
                  rsp_scrolled_ff <= scrolled_ff;
                  state_ff        <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // channel outputs
   assign req_bus.ready      = (state_ff == S_IDLE);
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.cursor_col = rsp_col_ff;
   assign rsp_bus.cursor_row = rsp_row_ff;
   assign rsp_bus.cursor_pos = rsp_pos_ff;
   assign rsp_bus.cell_word  = rsp_word_ff;
   assign rsp_bus.scrolled   = rsp_scrolled_ff;

   // checks
   `TCCE_ASSERT_IMP(a_cursor_on_screen, state_ff == S_FINAL,
                    (cur_row_ff < rows_ff) && (cur_col_ff < cols_ff),
                    "cursor left the screen")
   `TCCE_ASSERT_IMP(a_write_on_screen, ram_we && (state_ff != S_INIT),
                    wr_idx < total_ff, "store write beyond screen")
   `TCCE_ASSERT_IMP(a_scroll_last_row, (state_ff == S_FINAL) && scrolled_ff,
                    cur_row_ff == (rows_ff - RW'(1)), "scroll left cursor off last row")
   `TCCE_ASSERT_NXT(a_rsp_drops, rsp_fire && (state_ff != S_OUT),
                    !rsp_bus.valid, "result repeated after transaction")

endmodule

@@ sv/tcce_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the screen store.
module tcce_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ sv/tcce_mac.sv @@
// Shared multiply-add unit: q = a * b + c, registered, loaded when enabled.
// No dependencies; used for the screen size and every cursor position.
module tcce_mac #(
   parameter int A_W = 6,
   parameter int B_W = 8,
   parameter int Q_W = 13
) (
   input  logic           clock,
   input  logic           en,
   input  logic [A_W-1:0] a,
   input  logic [B_W-1:0] b,
   input  logic [B_W-1:0] c,
   output logic [Q_W-1:0] q
);
   localparam int S_W = A_W + B_W + 1;

   logic [S_W-1:0] sum;
   logic [Q_W-1:0] q_ff;

   assign sum = S_W'(a) * S_W'(b) + S_W'(c);

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff <= Q_W'(sum);
      end
   end

   assign q = q_ff;
endmodule

@@ tb/tb_text_console_cursor_engine_unit.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for text_console_cursor_engine_unit: directed and random
// console traffic, with a scoreboard that tracks the screen and cursor on its own.
// Depends on tcce_pkg, the channel interfaces in tcce_if.sv and the block's RTL.
module tb_text_console_cursor_engine_unit;
   import tcce_pkg::*;

   localparam logic [OPCODE_W-1:0]    OP_UNUSED  = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 2'd3;
   localparam int                     STORE_CELLS = DEF_MAX_ROWS * DEF_MAX_COLS;

   typedef struct packed {
      logic [OUT_COL_W-1:0] col;
      logic [OUT_ROW_W-1:0] row;
      logic [OUT_POS_W-1:0] pos;
      logic [CELL_W-1:0]    word;
      logic                 scrolled;
   } cursor_report_type;

   // Tracks screen contents, cursor and registers; holds the reports still owed
   class cursor_tracker_type;
      logic [CELL_W-1:0]     cells [STORE_CELLS];
      int unsigned           col_at;
      int unsigned           row_at;
      logic [CSR_DATA_W-1:0] attr;
      logic [5:0]            row_setting;
      logic [7:0]            col_setting;
      cursor_report_type     awaited_reports[$];
      int unsigned           failures;

      function new();
         foreach (cells[i]) cells[i] = RESET_CELL;
         col_at      = 0;
         row_at      = 0;
         attr        = ATTR_RESET;
         row_setting = 6'(ROWS_RESET);
         col_setting = 8'(COLS_RESET);
         failures    = 0;
      endfunction

      function int unsigned screen_rows();
         if (row_setting == 0) return 1;
         if (row_setting > DEF_MAX_ROWS) return DEF_MAX_ROWS;
         return row_setting;
      endfunction

      function int unsigned screen_cols();
         if (col_setting == 0) return 1;
         if (col_setting > DEF_MAX_COLS) return DEF_MAX_COLS;
         return col_setting;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            REG_ATTRIBUTE:    attr = val;
            REG_ROW_COUNT:    row_setting = val[5:0];
            REG_COLUMN_COUNT: col_setting = val;
            default: ;
         endcase
      endfunction

      // Apply one accepted command and queue the cursor report it produces
      function void note_command(logic [OPCODE_W-1:0] op, logic [CHAR_W-1:0] ch,
                                 logic [ADDR_W-1:0] addr);
         int unsigned    rows, cols, total, i;
         logic [CELL_W-1:0] blank;
         logic           down;
         cursor_report_type rep;
         rows  = screen_rows();
         cols  = screen_cols();
         total = rows * cols;
         blank = {attr, CH_BLANK};
         down  = 1'b0;
         rep   = '0;
         // a shrunk screen pulls the cursor back inside first
         if (col_at >= cols) col_at = cols - 1;
         if (row_at >= rows) row_at = rows - 1;
         case (op)
            OP_PUT: begin
               if (ch == CH_NEWLINE) begin
                  col_at = 0;
                  down   = 1'b1;
               end else if (ch == CH_BACKSPACE) begin
                  if (col_at > 0 || row_at > 0) begin
                     if (col_at > 0) begin
                        col_at--;
                     end else begin
                        row_at--;
                        col_at = cols - 1;
                     end
                     cells[row_at * cols + col_at] = blank;
                  end
               end else if (ch != CH_RETURN) begin
                  cells[row_at * cols + col_at] = {attr, ch};
                  col_at++;
                  if (col_at >= cols) begin
                     col_at = 0;
                     down   = 1'b1;
                  end
               end
               if (down) begin
                  if (row_at + 1 >= rows) begin
                     for (i = 0; i + cols < total; i++) cells[i] = cells[i + cols];
                     for (i = total - cols; i < total; i++) cells[i] = blank;
                     rep.scrolled = 1'b1;
                  end else begin
                     row_at++;
                  end
               end
            end
            OP_CLEAR: begin
               for (i = 0; i < total; i++) cells[i] = blank;
            end
            OP_READ: begin
               if (addr < total) rep.word = cells[addr];
            end
            default: ;
         endcase
         rep.col = col_at[OUT_COL_W-1:0];
         rep.row = row_at[OUT_ROW_W-1:0];
         rep.pos = OUT_POS_W'(row_at * cols + col_at);
         awaited_reports.push_back(rep);
      endfunction

      // Compare one received report with the oldest one owed
      function void check_report(cursor_report_type got);
         cursor_report_type want;
         if (awaited_reports.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("%0t: result with none outstanding: col %0d row %0d pos %0d word %h scr %b",
                        $time, got.col, got.row, got.pos, got.word, got.scrolled);
            return;
         end
         want = awaited_reports.pop_front();
         if (got.col !== want.col || got.row !== want.row || got.pos !== want.pos ||
             got.word !== want.word || got.scrolled !== want.scrolled) begin
            failures++;
            if (failures <= 10) begin
               $write("%0t: mismatch exp col %0d row %0d pos %0d word %h scr %b,",
                      $time, want.col, want.row, want.pos, want.word, want.scrolled);
               $display(" got col %0d row %0d pos %0d word %h scr %b",
                        got.col, got.row, got.pos, got.word, got.scrolled);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   quiet = 1'b0;
   int unsigned random_sent = 0;
   cursor_tracker_type tracker = new();

   tcce_req_if req_bus ();
   tcce_rsp_if rsp_bus ();
   tcce_csr_if csr_bus ();

   text_console_cursor_engine_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #4 clock = ~clock;

   // Mostly no gap, sometimes a short one, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Present one command and hold it until the block takes it
   task automatic send_command(logic [OPCODE_W-1:0] op, logic [CHAR_W-1:0] ch,
                               logic [ADDR_W-1:0] addr);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.opcode       <= op;
      req_bus.char_code    <= ch;
      req_bus.cell_address <= addr;
      do @(posedge clock); while (!req_bus.ready);
      tracker.note_command(op, ch, addr);
   endtask

   // Register write; the caller drops csr valid after the last one
   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (!csr_bus.ready);
      tracker.write_register(idx, val);
   endtask

   task automatic configure(logic [7:0] attr, logic [7:0] rows, logic [7:0] cols,
                            bit poke_unused);
      write_register(REG_ATTRIBUTE, attr);
      write_register(REG_ROW_COUNT, rows);
      write_register(REG_COLUMN_COUNT, cols);
      if (poke_unused) write_register(REG_UNUSED, 8'hFF);
      csr_bus.valid <= 1'b0;
      quiet = ($urandom_range(0, 3) == 0);
   endtask

   // Let every owed report come back, then idle longer for the sequencer
   task automatic drain_pending();
      req_bus.valid <= 1'b0;
      while (tracker.awaited_reports.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic run_random_items(int unsigned count);
      int unsigned pick, cells;
      logic [OPCODE_W-1:0] op;
      logic [CHAR_W-1:0]   ch;
      logic [ADDR_W-1:0]   addr;
      for (int unsigned k = 0; k < count; k++) begin
         cells = tracker.screen_rows() * tracker.screen_cols();
         ch    = CHAR_W'($urandom_range(0, 255));
         addr  = ADDR_W'($urandom_range(0, 4095));
         pick  = $urandom_range(0, 99);
         if (pick < 55) begin
            op   = OP_PUT;
            pick = $urandom_range(0, 99);
            if (pick < 10) ch = CH_NEWLINE;
            else if (pick < 18) ch = CH_BACKSPACE;
            else if (pick < 21) ch = CH_RETURN;
         end else if (pick < 86) begin
            op = OP_READ;
            if ($urandom_range(0, 4) != 0) addr = ADDR_W'($urandom_range(0, cells - 1));
         end else if (pick < 89) begin
            op = OP_CLEAR;
         end else begin
            op = OP_UNUSED;
         end
         send_command(op, ch, addr);
      end
      random_sent += count;
   endtask

   // Result side: random back-pressure, check every accepted transaction
   initial begin : result_drain
      int unsigned       stall;
      cursor_report_type got;
      stall = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.col      = rsp_bus.cursor_col;
            got.row      = rsp_bus.cursor_row;
            got.pos      = rsp_bus.cursor_pos;
            got.word     = rsp_bus.cell_word;
            got.scrolled = rsp_bus.scrolled;
            tracker.check_report(got);
         end
         if (stall > 0) begin
            stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall = pick_gap();
         end
      end
   end

   // Stimulus
   initial begin : stimulus
      int unsigned waited;
      req_bus.valid        = 1'b0;
      req_bus.opcode       = OP_PUT;
      req_bus.char_code    = '0;
      req_bus.cell_address = '0;
      csr_bus.valid        = 1'b0;
      csr_bus.index        = REG_ATTRIBUTE;
      csr_bus.data         = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed, reset screen of 25 x 80
      send_command(OP_READ, 8'h00, 12'd0);
      send_command(OP_READ, 8'h00, 12'd1999);
      send_command(OP_READ, 8'h00, 12'd2000);
      send_command(OP_PUT, CH_BACKSPACE, 12'd0);
      send_command(OP_PUT, 8'h41, 12'd0);
      send_command(OP_PUT, 8'h00, 12'd0);
      send_command(OP_PUT, 8'hFF, 12'hFFF);
      send_command(OP_PUT, CH_RETURN, 12'd0);
      send_command(OP_PUT, CH_BACKSPACE, 12'd0);
      send_command(OP_READ, 8'hFF, 12'd1);
      send_command(OP_PUT, CH_NEWLINE, 12'd0);
      send_command(OP_PUT, CH_BACKSPACE, 12'd0);
      send_command(OP_UNUSED, 8'h5A, 12'hA5A);
      send_command(OP_CLEAR, 8'h00, 12'd0);
      drain_pending();

      // directed, 2 x 3 screen: wrap, scroll on wrap and on newline, clear
      configure(8'h1E, 8'd2, 8'd3, 1'b0);
      send_command(OP_PUT, 8'h61, 12'd0);
      send_command(OP_PUT, 8'h62, 12'd0);
      send_command(OP_PUT, 8'h63, 12'd0);
      send_command(OP_PUT, 8'h64, 12'd0);
      send_command(OP_PUT, 8'h65, 12'd0);
      send_command(OP_PUT, 8'h66, 12'd0);
      send_command(OP_READ, 8'h00, 12'd0);
      send_command(OP_READ, 8'h00, 12'd3);
      send_command(OP_READ, 8'h00, 12'd6);
      send_command(OP_PUT, CH_NEWLINE, 12'd0);
      send_command(OP_PUT, CH_BACKSPACE, 12'd0);
      send_command(OP_CLEAR, 8'h00, 12'd0);
      drain_pending();

      // extremes of the registers, including zero and saturated counts
      configure(8'h00, 8'd32, 8'd128, 1'b0);
      run_random_items(40);
      drain_pending();
      configure(8'hFF, 8'd1, 8'd1, 1'b0);
      run_random_items(60);
      drain_pending();
      configure(8'($urandom_range(0, 255)), 8'd0, 8'd0, 1'b0);
      run_random_items(40);
      drain_pending();
      configure(8'($urandom_range(0, 255)), 8'd63, 8'd255, 1'b0);
      run_random_items(20);
      drain_pending();
      configure(8'($urandom_range(0, 255)), 8'd1, 8'd200, 1'b0);
      run_random_items(60);
      drain_pending();
      configure(8'($urandom_range(0, 255)), 8'd32, 8'd1, 1'b0);
      run_random_items(60);
      drain_pending();
      configure(8'($urandom_range(0, 255)), 8'hE3, 8'd2, 1'b1);
      run_random_items(40);
      drain_pending();

      // small screens keep scroll and clear cheap
      while (random_sent < 1100) begin
         configure(8'($urandom_range(0, 255)), 8'($urandom_range(1, 8)),
                   8'($urandom_range(1, 16)), 1'b0);
         run_random_items($urandom_range(60, 120));
         drain_pending();
      end

      waited = 0;
      while (tracker.awaited_reports.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (tracker.awaited_reports.size() != 0)
         $display("%0d results never arrived", tracker.awaited_reports.size());
      if (tracker.failures == 0 && tracker.awaited_reports.size() == 0) begin
         $display("PASS text_console_cursor_engine_unit");
      end else begin
         $display("FAIL text_console_cursor_engine_unit");
      end
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #32_000_000;
      $display("FAIL text_console_cursor_engine_unit");
      $finish;
   end

endmodule
